@@ sv/sha256_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions of the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned PosW       = $clog2(BlockBytes);
    localparam int unsigned BlockW     = 8 * BlockBytes;
    localparam int unsigned LenW       = 61;
    localparam logic [7:0]  PadByte    = 8'h80;

    // word 0 sits in the low bits
    localparam logic [7:0][31:0] InitHash = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // controls from the sequencer to the compression unit
    typedef struct packed {
        logic       init;
        logic       load;
        logic       start;
        logic [7:0] data;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big0(input logic [31:0] x);
        big0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big1(input logic [31:0] x);
        big1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml0(input logic [31:0] x);
        sml0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml1(input logic [31:0] x);
        sml1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        round_k = k;
    endfunction

endpackage
`default_nettype wire

@@ sv/sha256_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_if
// Valid/ready channels: message bytes in, digest words out.
// ----------------------------------------------------------------------------
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output message_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input message_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;

    modport source (output valid, output digest_word, output word_number,
                    output final_word, input ready);
    modport sink   (input valid, input digest_word, input word_number,
                    input final_word, output ready);
endinterface
`default_nettype wire

@@ sv/sha256_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_core
// Block shift line, message schedule and one shared round per cycle.
// ----------------------------------------------------------------------------
module sha256_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire sha256_pkg::t_core_ctl i_ctl,
    output sha256_pkg::t_core_sts      o_sts,
    output logic [7:0][31:0]           o_hash
);

    // oldest schedule word sits at the top of the line
    logic [sha256_pkg::BlockW-1:0] r_blk;
    logic [7:0][31:0]              r_v;
    logic [7:0][31:0]              r_h;
    logic [5:0]                    r_rnd;
    logic                          r_run;
    logic                          r_add;

    logic [31:0] w_t, w_1, w_9, w_14, w_new;
    logic [31:0] ch, maj, t1, t2;

    assign w_t   = r_blk[511:480];
    assign w_1   = r_blk[479:448];
    assign w_9   = r_blk[223:192];
    assign w_14  = r_blk[63:32];
    assign w_new = sha256_pkg::sml1(w_14) + w_9 + sha256_pkg::sml0(w_1) + w_t;

    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + sha256_pkg::big1(r_v[4]) + ch + sha256_pkg::round_k(r_rnd) + w_t;
    assign t2  = sha256_pkg::big0(r_v[0]) + maj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_add <= 1'b0;
            r_rnd <= '0;
            r_h   <= sha256_pkg::InitHash;
        end else begin
            if (i_ctl.start) begin
                r_run <= 1'b1;
                r_rnd <= '0;
            end else if (r_run) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_run <= 1'b0;
                    r_add <= 1'b1;
                end
            end else if (r_add) begin
                r_add <= 1'b0;
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end else if (i_ctl.init) begin
                r_h <= sha256_pkg::InitHash;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_v <= r_h;
        end else if (r_run) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            r_blk  <= {r_blk[sha256_pkg::BlockW-33:0], w_new};
        end else if (i_ctl.load) begin
            r_blk <= {r_blk[sha256_pkg::BlockW-9:0], i_ctl.data};
        end
    end

    assign o_sts.busy = r_run | r_add;
    assign o_sts.done = r_add;
    assign o_hash     = r_h;

endmodule
`default_nettype wire

@@ sv/sha256_message_hasher.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 of a byte stream, eight digest words out per message.
// ----------------------------------------------------------------------------
// A byte that does not complete a 64-byte block is taken, and the hasher
// stays ready. The byte that completes a block is followed by compression
// (a start step, 64 rounds on the single shared round unit, one
// feed-forward add), and no further byte is taken until it ends. A final
// request then shifts the padding in one byte a cycle up to the end of the
// block, compresses once or twice, and returns eight words through an
// output register; the next message may start while the last word waits.
module sha256_message_hasher (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    sha256_in_if.sink     i_msg,
    sha256_out_if.source  o_dig
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_KICK = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]                      r_state;
    logic [sha256_pkg::PosW-1:0]     r_pos;
    logic [sha256_pkg::PosW-1:0]     n_pos;
    logic [sha256_pkg::LenW-1:0]     r_len;
    logic                            r_pad;
    logic                            r_first;
    logic                            r_extra;
    logic                            r_final;
    logic [2:0]                      r_widx;
    logic                            r_ov;
    logic [31:0]                     r_word;
    logic [2:0]                      r_onum;

    sha256_pkg::t_core_ctl core_ctl;
    sha256_pkg::t_core_sts core_sts;
    logic [7:0][31:0]      hash;

    logic        accept;
    logic [63:0] len_bits;
    logic [7:0]  pad_byte;
    logic        ext;
    logic        out_load;

    assign accept   = i_msg.valid & i_msg.ready;
    assign len_bits = {r_len, 3'b000};
    assign n_pos    = r_pos + 1'b1;
    assign ext      = r_first ? (r_pos[5:3] == 3'b111) : r_extra;
    assign out_load = (r_state == S_OUT) && (!r_ov || o_dig.ready);

    // length bytes go big-endian into the last eight slots of the final block
    always_comb begin
        if (r_first) begin
            pad_byte = sha256_pkg::PadByte;
        end else if (!r_extra && r_pos[5:3] == 3'b111) begin
            pad_byte = len_bits[{~r_pos[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        core_ctl.init  = out_load && (r_widx == 3'd7);
        core_ctl.start = (r_state == S_KICK);
        core_ctl.load  = (accept && i_msg.byte_present) || (r_state == S_PAD);
        core_ctl.data  = (r_state == S_PAD) ? pad_byte : i_msg.message_byte;
    end

    sha256_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .o_sts   (core_sts),
        .o_hash  (hash)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_len   <= '0;
            r_pad   <= 1'b0;
            r_first <= 1'b0;
            r_extra <= 1'b0;
            r_final <= 1'b0;
            r_widx  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_dig.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_msg.byte_present) begin
                            r_pos <= n_pos;
                            r_len <= r_len + 1'b1;
                        end
                        if (i_msg.end_of_message) begin
                            r_pad   <= 1'b1;
                            r_first <= 1'b1;
                            r_extra <= 1'b0;
                            r_final <= 1'b0;
                        end
                        if (i_msg.byte_present && r_pos == '1) begin
                            r_state <= S_KICK;
                        end else if (i_msg.end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_pos   <= n_pos;
                    r_first <= 1'b0;
                    if (r_pos == '1) begin
                        r_final <= !ext;
                        r_extra <= 1'b0;
                        r_state <= S_KICK;
                    end else begin
                        r_extra <= ext;
                    end
                end
                S_KICK: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (core_sts.done) begin
                        if (!r_pad) begin
                            r_state <= S_IDLE;
                        end else if (r_final) begin
                            r_state <= S_OUT;
                            r_widx  <= '0;
                        end else begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_widx <= r_widx + 3'd1;
                        if (r_widx == 3'd7) begin
                            r_state <= S_IDLE;
                            r_pos   <= '0;
                            r_len   <= '0;
                            r_pad   <= 1'b0;
                            r_final <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_word <= hash[r_widx];
            r_onum <= r_widx;
        end
    end

    assign i_msg.ready       = (r_state == S_IDLE);
    assign o_dig.valid       = r_ov;
    assign o_dig.digest_word = r_word;
    assign o_dig.word_number = r_onum;
    assign o_dig.final_word  = (r_onum == 3'd7);

    // no request is taken while a block is being compressed
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_msg.ready |-> !core_sts.busy)
        else $error("request accepted during compression");

    // the block line must not shift bytes while rounds run
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_ctl.load |-> !core_sts.busy && !core_ctl.start)
        else $error("byte loaded into busy core");

    // digest words leave back to back in order
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dig.valid && o_dig.ready && (o_dig.word_number != 3'd7)
        |=> o_dig.valid && (o_dig.word_number == $past(o_dig.word_number) + 3'd1))
        else $error("digest word order broken");

endmodule
`default_nettype wire
